/* rtl/core/shfd_pkg.sv */
package shfd_pkg;

  // Frame layout
  localparam int unsigned CommandCount = 16;
  localparam int unsigned CmdW         = 4;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned EnW          = 16;

  localparam logic [ByteW-1:0] SyncFirst  = 8'h65;  // 'e'
  localparam logic [ByteW-1:0] SyncSecond = 8'h52;  // 'R'

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  // One result word
  typedef struct packed {
    logic [CmdW-1:0]  command_number;
    logic [ByteW-1:0] payload_byte;
    logic             last_of_frame;
    logic             empty_frame;
  } result_t;

  // Parser to output register
  typedef struct packed {
    logic    emit;
    result_t res;
  } emit_t;

endpackage

/* rtl/core/shfd_in_reg.sv */
module shfd_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [shfd_pkg::ByteW-1:0] rx_byte_i,
  input  logic                       adv_i,
  output logic                       in_stall_o,
  output logic                       vld_o,
  output logic [shfd_pkg::ByteW-1:0] byte_o
);

  logic                       vld_q;
  logic                       vld_d;
  logic [shfd_pkg::ByteW-1:0] byte_q;
  logic                       load;

  // Hold the word while the parser cannot advance
  assign in_stall_o = vld_q && !adv_i;
  assign load       = in_valid_i && !in_stall_o;
  assign vld_d      = load ? 1'b1 : (adv_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

/* rtl/core/shfd_parser.sv */
module shfd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [shfd_pkg::EnW-1:0]   cfg_wdata_i,
  input  logic                       adv_i,
  input  logic [shfd_pkg::ByteW-1:0] byte_i,
  output shfd_pkg::emit_t            emit_o
);

  shfd_pkg::phase_e           phase_q, phase_d;
  logic [shfd_pkg::ByteW-1:0] cmd_q, cmd_d;
  logic [shfd_pkg::ByteW-1:0] rem_q, rem_d;
  logic                       disc_q, disc_d;
  logic [shfd_pkg::EnW-1:0]   en_q;
  logic                       in_range;
  logic                       cmd_en;
  logic [shfd_pkg::ByteW-1:0] rem_dec;
  logic                       pay_last;

  // Command checks on the latched type byte
  assign in_range = cmd_q < shfd_pkg::ByteW'(shfd_pkg::CommandCount);
  assign cmd_en   = in_range && (cmd_q < shfd_pkg::ByteW'(shfd_pkg::EnW))
                    && en_q[cmd_q[shfd_pkg::CmdW-1:0]];
  assign rem_dec  = rem_q - 8'd1;
  assign pay_last = (rem_dec == '0);

  // Next state
  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    rem_d   = rem_q;
    disc_d  = disc_q;
    case (phase_q)
      shfd_pkg::PH_SYNC2: begin
        phase_d = (byte_i == shfd_pkg::SyncSecond) ? shfd_pkg::PH_TYPE : shfd_pkg::PH_HUNT;
      end
      shfd_pkg::PH_TYPE: begin
        cmd_d   = byte_i;
        phase_d = shfd_pkg::PH_LEN;
      end
      shfd_pkg::PH_LEN: begin
        rem_d = byte_i;
        if (!in_range) begin
          phase_d = shfd_pkg::PH_HUNT;
        end else begin
          disc_d  = !cmd_en;
          phase_d = (byte_i == '0) ? shfd_pkg::PH_HUNT : shfd_pkg::PH_PAYLOAD;
        end
      end
      shfd_pkg::PH_PAYLOAD: begin
        rem_d = rem_dec;
        if (pay_last) begin
          phase_d = shfd_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_d = (byte_i == shfd_pkg::SyncFirst) ? shfd_pkg::PH_SYNC2 : shfd_pkg::PH_HUNT;
      end
    endcase
  end

  // Result word
  always_comb begin
    emit_o                    = '0;
    emit_o.res.command_number = cmd_q[shfd_pkg::CmdW-1:0];
    case (phase_q)
      shfd_pkg::PH_LEN: begin
        if (cmd_en && (byte_i == '0)) begin
          emit_o.emit              = adv_i;
          emit_o.res.last_of_frame = 1'b1;
          emit_o.res.empty_frame   = 1'b1;
        end
      end
      shfd_pkg::PH_PAYLOAD: begin
        emit_o.emit              = adv_i && !disc_q;
        emit_o.res.payload_byte  = byte_i;
        emit_o.res.last_of_frame = pay_last;
      end
      default: begin
        emit_o.emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= shfd_pkg::PH_HUNT;
      cmd_q   <= '0;
      rem_q   <= '0;
      disc_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      rem_q   <= rem_d;
      disc_q  <= disc_d;
    end
  end

  // Enable mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else if (cfg_we_i) begin
      en_q <= cfg_wdata_i;
    end
  end

endmodule

/* rtl/core/shfd_out_reg.sv */
module shfd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shfd_pkg::emit_t   emit_i,
  input  logic              out_stall_i,
  output logic              ready_o,
  output logic              out_valid_o,
  output shfd_pkg::result_t res_o
);

  logic              vld_q, vld_d;
  shfd_pkg::result_t res_q;

  // Free when empty or when the held word leaves this cycle
  assign ready_o = !vld_q || !out_stall_i;
  assign vld_d   = emit_i.emit ? 1'b1 : (ready_o ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.emit) begin
      res_q <= emit_i.res;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/sync_header_frame_dispatcher.sv */
// A byte accepted into the input register passes through the parser logic into
// the result register (input register, parser, result register); an output stall can hold it back.
// Throughput: one byte per cycle while the output is not stalled.
// Reset: asynchronous active low; parser returns to hunting 'e', the
// enable mask clears to zero, both word registers go empty.
module sync_header_frame_dispatcher (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [shfd_pkg::EnW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [shfd_pkg::ByteW-1:0] rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [shfd_pkg::CmdW-1:0]  command_number_o,
  output logic [shfd_pkg::ByteW-1:0] payload_byte_o,
  output logic                       last_of_frame_o,
  output logic                       empty_frame_o
);

  logic                       in_vld;
  logic [shfd_pkg::ByteW-1:0] in_byte;
  logic                       out_ready;
  logic                       adv;
  shfd_pkg::emit_t            emit;
  shfd_pkg::result_t          res;

  // Parser advances when a word is held and the result register can take a word
  assign adv = in_vld && out_ready;

  shfd_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .adv_i      (adv),
    .in_stall_o (in_stall_o),
    .vld_o      (in_vld),
    .byte_o     (in_byte)
  );

  shfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .byte_i      (in_byte),
    .emit_o      (emit)
  );

  shfd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign command_number_o = res.command_number;
  assign payload_byte_o   = res.payload_byte;
  assign last_of_frame_o  = res.last_of_frame;
  assign empty_frame_o    = res.empty_frame;

  // Empty-frame marker is always a final, zero-data word
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_frame_o) |-> (last_of_frame_o && (payload_byte_o == '0)))
    else $error("empty-frame marker malformed");

  // Input is held back only by a stalled, full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld && out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // A taken result with no new word behind it leaves the register empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !emit.emit) |=> !out_valid_o)
    else $error("result register did not drain");

  // Nothing is emitted unless the parser advances
  a_emit_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.emit |-> adv)
    else $error("result emitted without parser advance");

endmodule
